>>> hw/rtl/hrp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request head parser: shared package
// Field caps, character and result codes, parse phases and the structures
// that carry parse state and result items between the parser parts.
// ----------------------------------------------------------------------------
package hrp_pkg;

  // Field caps in bytes.
  localparam int METHOD_MAX  = 16;
  localparam int ROUTE_MAX   = 256;
  localparam int VERSION_MAX = 16;
  localparam int VALUE_MAX   = 128;

  // The field byte counter must be able to hold the largest cap itself.
  localparam int TOKEN_CAP = (METHOD_MAX > VERSION_MAX) ? METHOD_MAX : VERSION_MAX;
  localparam int LINE_CAP  = (ROUTE_MAX > TOKEN_CAP) ? ROUTE_MAX : TOKEN_CAP;
  localparam int CAP_MAX   = (VALUE_MAX > LINE_CAP) ? VALUE_MAX : LINE_CAP;
  localparam int CNT_W     = $clog2(CAP_MAX + 1);

  // Known header names, right-justified in a packed vector.
  localparam int NUM_HDR    = 6;
  localparam int HDR_NAME_W = 128;
  localparam int NAME_POS_W = 5;

  localparam logic [HDR_NAME_W-1:0] HDR_NAME [NUM_HDR] = '{
    "Host", "User-Agent", "Accept", "Accept-Language", "Accept-Encoding", "Connection"
  };
  localparam logic [NAME_POS_W-1:0] HDR_LEN [NUM_HDR] = '{
    5'd4, 5'd10, 5'd6, 5'd15, 5'd15, 5'd10
  };

  // Result queue between the parser and the output stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Characters of interest.
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;

  // Result kinds.
  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Field tags.
  localparam logic [3:0] TAG_METHOD  = 4'd0;
  localparam logic [3:0] TAG_ROUTE   = 4'd1;
  localparam logic [3:0] TAG_VERSION = 4'd2;
  localparam logic [3:0] TAG_HOST    = 4'd3;

  // Parse phases.
  typedef enum logic [3:0] {
    PH_M_PRE   = 4'd0,
    PH_M_TOK   = 4'd1,
    PH_R_PRE   = 4'd2,
    PH_R_TOK   = 4'd3,
    PH_V_PRE   = 4'd4,
    PH_V_TOK   = 4'd5,
    PH_RL_REST = 4'd6,
    PH_H_NAME  = 4'd7,
    PH_H_VPRE  = 4'd8,
    PH_H_VAL   = 4'd9,
    PH_H_SKIP  = 4'd10,
    PH_DONE    = 4'd11
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic [CNT_W-1:0]      field_count;
    logic [NUM_HDR-1:0]    name_match;
    logic [NAME_POS_W-1:0] name_pos;
    logic [3:0]            header_sel;
    logic                  cr_pending;
    logic [1:0]            tokens_seen;
    logic                  dropped;
  } parse_state_t;

  // One result item, without its end-of-run mark.
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] tag;
    logic [7:0] value;
    logic       trunc;
    logic       comp;
  } res_t;

  // All results caused by one input byte: count (one or two) and the items.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } run_t;

endpackage

>>> hw/rtl/hrp_ifs.sv
// ----------------------------------------------------------------------------
// HTTP request head parser: channel interfaces
// Valid/ready channels for request bytes and for parse results.
// ----------------------------------------------------------------------------
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_request;

  modport source(output valid, data_byte, new_request, input ready);
  modport sink(input valid, data_byte, new_request, output ready);
endinterface

interface hrp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] field_tag;
  logic [7:0] value_byte;
  logic       was_truncated;
  logic       line_complete;
  logic       last_of_run;

  modport source(output valid, kind, field_tag, value_byte, was_truncated, line_complete,
                 last_of_run, input ready);
  modport sink(input valid, kind, field_tag, value_byte, was_truncated, line_complete,
               last_of_run, output ready);
endinterface

>>> hw/rtl/hrp_front.sv
// ----------------------------------------------------------------------------
// HTTP request head parser: front end
// Takes one request byte per cycle while the result queue has room, advances
// the parse state and pushes the byte's results into the queue as one run.
// ----------------------------------------------------------------------------
module hrp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data_byte,
  input  logic          in_new_request,
  input  logic          q_full,
  output logic          q_push,
  output hrp_pkg::run_t q_run
);
  import hrp_pkg::*;

  typedef struct packed {
    parse_state_t st;
    logic [1:0]   n;
    res_t         r0;
    res_t         r1;
  } ctx_t;

  parse_state_t state_r;
  parse_state_t state_nxt;
  ctx_t         step;
  logic         accept;

  function automatic parse_state_t reset_state();
    parse_state_t s;
    s.phase       = PH_M_PRE;
    s.field_count = '0;
    s.name_match  = '1;
    s.name_pos    = '0;
    s.header_sel  = '0;
    s.cr_pending  = 1'b0;
    s.tokens_seen = 2'd0;
    s.dropped     = 1'b0;
    return s;
  endfunction

  function automatic logic [CNT_W-1:0] cap_of(logic [3:0] tag);
    case (tag)
      TAG_METHOD:  return CNT_W'(METHOD_MAX);
      TAG_ROUTE:   return CNT_W'(ROUTE_MAX);
      TAG_VERSION: return CNT_W'(VERSION_MAX);
      default:     return CNT_W'(VALUE_MAX);
    endcase
  endfunction

  // Append a result to the run; a run holds at most two.
  function automatic ctx_t emit(ctx_t x, logic [1:0] kind, logic [3:0] tag,
                                logic [7:0] v, logic tr, logic cp);
    res_t r;
    r.kind  = kind;
    r.tag   = tag;
    r.value = v;
    r.trunc = tr;
    r.comp  = cp;
    if (x.n == 2'd0) begin
      x.r0 = r;
      x.n  = 2'd1;
    end else if (x.n == 2'd1) begin
      x.r1 = r;
      x.n  = 2'd2;
    end
    return x;
  endfunction

  function automatic ctx_t put_byte(ctx_t x, logic [3:0] tag, logic [7:0] c);
    if (x.st.field_count < cap_of(tag)) begin
      x.st.field_count = x.st.field_count + CNT_W'(1);
      x = emit(x, KIND_VALUE, tag, c, 1'b0, 1'b0);
    end else begin
      x.st.dropped = 1'b1;
    end
    return x;
  endfunction

  function automatic ctx_t field_end(ctx_t x, logic [3:0] tag);
    return emit(x, KIND_END, tag, 8'd0, x.st.dropped, 1'b0);
  endfunction

  function automatic ctx_t new_line(ctx_t x);
    x.st.phase       = PH_H_NAME;
    x.st.name_pos    = '0;
    x.st.name_match  = '1;
    x.st.header_sel  = '0;
    x.st.cr_pending  = 1'b0;
    x.st.field_count = '0;
    x.st.dropped     = 1'b0;
    return x;
  endfunction

  // End of a header line: an empty line closes the head.
  function automatic ctx_t close_line(ctx_t x);
    if (x.st.phase == PH_H_NAME && x.st.name_pos == '0) begin
      x = emit(x, KIND_DONE, TAG_METHOD, 8'd0, 1'b0, x.st.tokens_seen == 2'd3);
      x.st.phase      = PH_DONE;
      x.st.cr_pending = 1'b0;
    end else begin
      if (x.st.phase == PH_H_VPRE || x.st.phase == PH_H_VAL) begin
        x = field_end(x, x.st.header_sel);
      end
      x = new_line(x);
    end
    return x;
  endfunction

  // One ordinary byte of a header line.
  function automatic ctx_t hdr_byte(ctx_t x, logic [7:0] c);
    logic [3:0] sh;
    logic [3:0] sel;
    sh  = '0;
    sel = '0;
    case (x.st.phase)
      PH_H_NAME: begin
        if (c == CH_COLON) begin
          for (int k = 0; k < NUM_HDR; k++) begin
            if (x.st.name_match[k] && HDR_LEN[k] == x.st.name_pos) begin
              sel = 4'(k + 3);
            end
          end
          x.st.header_sel = sel;
          if (sel != '0) begin
            x.st.field_count = '0;
            x.st.dropped     = 1'b0;
            x.st.phase       = PH_H_VPRE;
          end else begin
            x.st.phase = PH_H_SKIP;
          end
        end else begin
          for (int k = 0; k < NUM_HDR; k++) begin
            sh = 4'(HDR_LEN[k] - 5'd1 - x.st.name_pos);
            if (x.st.name_pos >= HDR_LEN[k] || HDR_NAME[k][{sh, 3'b000} +: 8] != c) begin
              x.st.name_match[k] = 1'b0;
            end
          end
          if (x.st.name_pos != '1) begin
            x.st.name_pos = x.st.name_pos + NAME_POS_W'(1);
          end
        end
      end
      PH_H_VPRE: begin
        if (c != CH_SP) begin
          x.st.phase = PH_H_VAL;
          x = put_byte(x, x.st.header_sel, c);
        end
      end
      PH_H_VAL: begin
        x = put_byte(x, x.st.header_sel, c);
      end
      default: begin
      end
    endcase
    return x;
  endfunction

  // One byte of the request line.
  function automatic ctx_t rl_byte(ctx_t x, logic [7:0] c);
    logic [3:0] p;
    logic [3:0] tag;
    p   = x.st.phase;
    tag = {1'b0, p[3:1]};
    case (x.st.phase)
      PH_M_PRE, PH_R_PRE, PH_V_PRE: begin
        if (c == CH_SP || (x.st.phase == PH_M_PRE && (c == CH_CR || c == CH_LF))) begin
          x = x;
        end else if (c == CH_CR) begin
          x.st.phase = PH_RL_REST;
        end else if (c == CH_LF) begin
          x = new_line(x);
        end else begin
          x.st.tokens_seen = 2'(tag + 4'd1);
          x.st.field_count = '0;
          x.st.dropped     = 1'b0;
          x.st.phase       = phase_t'(p + 4'd1);
          x = put_byte(x, tag, c);
        end
      end
      PH_M_TOK, PH_R_TOK, PH_V_TOK: begin
        if (c == CH_CR) begin
          x = field_end(x, tag);
          x.st.phase = PH_RL_REST;
        end else if (c == CH_LF) begin
          x = field_end(x, tag);
          x = new_line(x);
        end else if (c == CH_SP && x.st.phase != PH_V_TOK) begin
          x = field_end(x, tag);
          x.st.phase = phase_t'(p + 4'd1);
        end else begin
          x = put_byte(x, tag, c);
        end
      end
      default: begin
        if (c == CH_LF) begin
          x = new_line(x);
        end
      end
    endcase
    return x;
  endfunction

  // Work out the effect of the offered byte.
  always_comb begin
    logic consumed;
    consumed = 1'b0;
    step.n   = 2'd0;
    step.r0  = '0;
    step.r1  = '0;
    step.st  = in_new_request ? reset_state() : state_r;
    if (step.st.phase <= PH_RL_REST) begin
      step = rl_byte(step, in_data_byte);
    end else if (step.st.phase <= PH_H_SKIP) begin
      // A held CR either closes the line or turns out to be a line byte.
      if (step.st.cr_pending) begin
        step.st.cr_pending = 1'b0;
        if (in_data_byte == CH_LF) begin
          step     = close_line(step);
          consumed = 1'b1;
        end else begin
          step = hdr_byte(step, CH_CR);
        end
      end
      if (!consumed) begin
        if (in_data_byte == CH_CR) begin
          step.st.cr_pending = 1'b1;
        end else if (in_data_byte == CH_LF) begin
          step = close_line(step);
        end else begin
          step = hdr_byte(step, in_data_byte);
        end
      end
    end
  end

  // Next state: the parse advances only on an accepted transaction.
  assign accept = in_valid && !q_full;

  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      state_nxt = step.st;
    end
  end

  // Outputs towards the queue.
  always_comb begin
    in_ready = !q_full;
    q_push   = accept && (step.n != 2'd0);
    q_run.n  = step.n;
    q_run.r0 = step.r0;
    q_run.r1 = step.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= reset_state();
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/hrp_queue.sv
// ----------------------------------------------------------------------------
// HTTP request head parser: result queue
// A short queue of result runs between the parser and the output stage.
// ----------------------------------------------------------------------------
module hrp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hrp_pkg::run_t push_run,
  output logic          full,
  input  logic          pop,
  output hrp_pkg::run_t head_run,
  output logic          nonempty
);
  import hrp_pkg::*;

  run_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;

  // Status.
  assign full     = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign nonempty = (count_r != '0);
  assign head_run = mem_r[rd_ptr_r];

  // Pointer and fill updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

  // The parser must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("result queue overflow");

  // The output stage must never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("result queue underflow");

  // Only runs that carry at least one result enter the queue.
  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_run.n == 2'd1 || push_run.n == 2'd2))
    else $error("empty run pushed");

  // A lone push raises the fill by exactly one.
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + (QPTR_W + 1)'(1)))
    else $error("queue fill count out of step");

endmodule

>>> hw/rtl/hrp_back.sv
// ----------------------------------------------------------------------------
// HTTP request head parser: output stage
// Takes runs from the queue and hands out their results one per transaction,
// marking the last result of each run.
// ----------------------------------------------------------------------------
module hrp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  hrp_pkg::run_t head_run,
  input  logic          q_nonempty,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [3:0]    out_field_tag,
  output logic [7:0]    out_value_byte,
  output logic          out_was_truncated,
  output logic          out_line_complete,
  output logic          out_last_of_run
);
  import hrp_pkg::*;

  run_t cur_r;
  run_t cur_nxt;
  logic valid_r;
  logic valid_nxt;
  logic sel_r;
  logic sel_nxt;
  logic last;
  logic advance;
  res_t res;

  // Current result and whether it closes its run.
  assign last    = sel_r || (cur_r.n == 2'd1);
  assign advance = valid_r && out_ready;
  assign q_pop   = q_nonempty && (!valid_r || (advance && last));
  assign res     = sel_r ? cur_r.r1 : cur_r.r0;

  always_comb begin
    cur_nxt   = cur_r;
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    if (q_pop) begin
      cur_nxt   = head_run;
      valid_nxt = 1'b1;
      sel_nxt   = 1'b0;
    end else if (advance) begin
      if (last) begin
        valid_nxt = 1'b0;
      end else begin
        sel_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Result channel.
  assign out_valid         = valid_r;
  assign out_kind          = res.kind;
  assign out_field_tag     = res.tag;
  assign out_value_byte    = res.value;
  assign out_was_truncated = res.trunc;
  assign out_line_complete = res.comp;
  assign out_last_of_run   = last;

endmodule

>>> hw/rtl/http_request_head_parser.sv
// ----------------------------------------------------------------------------
// HTTP request head parser
// Splits a request byte stream into request-line tokens and known header
// values, streaming tagged value bytes, field ends and a head-complete item.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction
//  in_chan   sink       one request byte and its new-request mark
//  out_chan  source     one result item, last_of_run on the final item of a byte
//
//  A byte is taken every cycle while the result queue has room; its results
//  are written into the queue, then loaded into the output register.
//  The output side hands out one result per cycle while the sink is ready,
//  so bytes causing two results cost two transactions; the queue absorbs
//  short bursts of them. Reset is synchronous and active low.
//  The input stalls only when the queue is full; output stalls back up into
//  the queue and never discard a result.
// ----------------------------------------------------------------------------
module http_request_head_parser (
  input logic       clk,
  input logic       rst_n,
  hrp_in_if.sink    in_chan,
  hrp_out_if.source out_chan
);
  import hrp_pkg::*;

  logic q_full;
  logic q_push;
  run_t q_run;
  logic q_pop;
  run_t head_run;
  logic q_nonempty;

  // Parser front end.
  hrp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_data_byte   (in_chan.data_byte),
    .in_new_request (in_chan.new_request),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_run          (q_run)
  );

  // Queue of result runs.
  hrp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_run (q_run),
    .full     (q_full),
    .pop      (q_pop),
    .head_run (head_run),
    .nonempty (q_nonempty)
  );

  // Output stage.
  hrp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_run          (head_run),
    .q_nonempty        (q_nonempty),
    .q_pop             (q_pop),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_kind          (out_chan.kind),
    .out_field_tag     (out_chan.field_tag),
    .out_value_byte    (out_chan.value_byte),
    .out_was_truncated (out_chan.was_truncated),
    .out_line_complete (out_chan.line_complete),
    .out_last_of_run   (out_chan.last_of_run)
  );

endmodule
